>>> hdl/pelc_pkg.sv
// ----------------------------------------------------------------------------
// pelc_pkg: shared types and constants for the proton energy-loss chain
// Item types, fixed-point widths, fitted coefficient tables and their Q40
// conversion, path clamp bounds.
// ----------------------------------------------------------------------------
package pelc_pkg;

	localparam int QBITS   = 40;
	localparam int ACC_W   = 58;
	localparam int B_W     = 41;
	localparam int MUL_LAT = 3;
	localparam int NSTEP   = 10;
	localparam int POLY_LAT = NSTEP * MUL_LAT;

	localparam int E_LO_MEV = 75;
	localparam int E_HI_MEV = 275;
	localparam logic [16:0] OUT_MAX = 17'h1FFFF;

	localparam logic [41:0] YS_LO = 42'((64'd13 << 37) / 64'd5);
	localparam logic [41:0] YS_HI = 42'((64'd33 << 37) / 64'd5);
	localparam logic [41:0] YA_LO = 42'(100) << 32;
	localparam logic [41:0] YA_HI = 42'(250) << 32;
	localparam logic [41:0] YC_LO = 42'(1) << 35;
	localparam logic [41:0] YC_HI = 42'(5) << 37;

	typedef struct packed {
		logic [16:0] energy_in;
		logic [13:0] scint_path;
		logic [14:0] air_path;
		logic [13:0] carbon_path;
	} cmd_t;

	typedef struct packed {
		logic [16:0] energy_after_scint;
		logic [16:0] energy_after_air;
		logic [16:0] energy_mid_carbon;
	} result_t;

	typedef struct packed {
		logic [B_W-1:0]             x;
		logic [B_W-1:0]             y;
		logic [5:0][ACC_W-1:0]      a;
	} step_t;

	localparam int YBITS [3] = '{2, 8, 3};

	localparam int COEF_M [3][6][6] = '{
		'{
			'{-124057, -271508, -309274, 227429, -175779, 276222},
			'{147853, 446048, 424844, 491351, -677075, 0},
			'{-709161, -362562, -294943, 363562, 0, 0},
			'{498646, 140909, 439253, 0, 0, 0},
			'{-167151, -197554, 0, 0, 0, 0},
			'{212392, 0, 0, 0, 0, 0}
		},
		'{
			'{-678814, -234935, -218614, -899602, 247416, -282056},
			'{10236, 28087, 2234, 135552, -103616, 0},
			'{-309939, -177498, -124622, -197975, 0, 0},
			'{193732, 541678, 220046, 0, 0, 0},
			'{-579446, -638132, 0, 0, 0, 0},
			'{666763, 0, 0, 0, 0, 0}
		},
		'{
			'{-180824, -438742, -497526, -388278, -627964, 108603},
			'{168021, 708271, 6826, 418985, 228446, 0},
			'{-962642, -544655, -313217, -108313, 0, 0},
			'{63999, 19044, 475607, 0, 0, 0},
			'{-200971, -246583, 0, 0, 0, 0},
			'{240173, 0, 0, 0, 0, 0}
		}
	};

	localparam int COEF_E [3][6][6] = '{
		'{
			'{4, 4, 5, 6, 6, 7},
			'{5, 6, 7, 8, 9, 0},
			'{8, 8, 9, 11, 0, 0},
			'{10, 10, 12, 0, 0, 0},
			'{12, 13, 0, 0, 0, 0},
			'{15, 0, 0, 0, 0, 0}
		},
		'{
			'{6, 7, 12, 14, 16, 19},
			'{4, 8, 11, 16, 19, 0},
			'{9, 11, 15, 19, 0, 0},
			'{11, 14, 18, 0, 0, 0},
			'{14, 17, 0, 0, 0, 0},
			'{17, 0, 0, 0, 0, 0}
		},
		'{
			'{4, 4, 5, 7, 8, 9},
			'{5, 6, 5, 9, 10, 0},
			'{8, 8, 9, 11, 0, 0},
			'{9, 9, 12, 0, 0, 0},
			'{12, 13, 0, 0, 0, 0},
			'{15, 0, 0, 0, 0, 0}
		}
	};

	function automatic logic signed [ACC_W-1:0] coef_q(int stage, int i, int j);
		logic [63:0] mag;
		logic [63:0] d;
		logic [63:0] r;
		logic [63:0] q;
		logic        carry;
		logic        bitv;
		int          m;
		int          e;
		int          n;
		int          k;
		m = COEF_M[stage][i][j];
		e = COEF_E[stage][i][j];
		n = 20 + QBITS + 8 * i + YBITS[stage] * j;
		mag = (m < 0) ? 64'(-m) : 64'(m);
		d = 64'd1;
		r = '0;
		q = '0;
		for (k = 0; k < e && k < 19; k++) begin
			d = d * 64'd10;
		end
		for (k = 0; k < n; k++) begin
			bitv = (k < 20) ? mag[19-k] : 1'b0;
			carry = r[63];
			r = {r[62:0], bitv};
			q = {q[62:0], 1'b0};
			if (carry || r >= d) begin
				r = r - d;
				q[0] = 1'b1;
			end
		end
		if (q[63]) begin
			q = 64'h7FFF_FFFF_FFFF_FFFF;
		end
		return (m < 0) ? ACC_W'(-$signed(q)) : ACC_W'($signed(q));
	endfunction

endpackage

>>> hdl/pelc_muladd.sv
// ----------------------------------------------------------------------------
// pelc_muladd: pipelined Q40 multiply-add
// p = trunc0(a * b / 2^40) + c over three register stages: partial
// products, product sum, sign and addend.
// ----------------------------------------------------------------------------
module pelc_muladd (
	input  logic                              clk,
	input  logic signed [pelc_pkg::ACC_W-1:0] a,
	input  logic        [pelc_pkg::B_W-1:0]   b,
	input  logic signed [pelc_pkg::ACC_W-1:0] c,
	output logic signed [pelc_pkg::ACC_W-1:0] p
);

	localparam int AW  = pelc_pkg::ACC_W;
	localparam int BW  = pelc_pkg::B_W;
	localparam int ALW = AW / 2;
	localparam int AHW = AW - ALW;
	localparam int BLW = (BW + 1) / 2;
	localparam int BHW = BW - BLW;
	localparam int SW  = AW + BW;

	logic [AW-1:0]         mag;
	logic [ALW+BLW-1:0]    pp_ll_s1;
	logic [ALW+BHW-1:0]    pp_lh_s1;
	logic [AHW+BLW-1:0]    pp_hl_s1;
	logic [AHW+BHW-1:0]    pp_hh_s1;
	logic                  neg_s1;
	logic signed [AW-1:0]  c_s1;
	logic [SW-1:0]         sum_s2;
	logic                  neg_s2;
	logic signed [AW-1:0]  c_s2;
	logic [AW-1:0]         q;

	assign mag = a[AW-1] ? AW'(-a) : AW'(a);

	always_ff @(posedge clk) begin
		pp_ll_s1 <= mag[ALW-1:0] * b[BLW-1:0];
		pp_lh_s1 <= mag[ALW-1:0] * b[BW-1:BLW];
		pp_hl_s1 <= mag[AW-1:ALW] * b[BLW-1:0];
		pp_hh_s1 <= mag[AW-1:ALW] * b[BW-1:BLW];
		neg_s1   <= a[AW-1];
		c_s1     <= c;
	end

	always_ff @(posedge clk) begin
		sum_s2 <= SW'(pp_ll_s1) + (SW'(pp_lh_s1) << BLW) + (SW'(pp_hl_s1) << ALW)
			+ (SW'(pp_hh_s1) << (ALW + BLW));
		neg_s2 <= neg_s1;
		c_s2   <= c_s1;
	end

	assign q = sum_s2[pelc_pkg::QBITS+AW-1:pelc_pkg::QBITS];

	always_ff @(posedge clk) begin
		p <= (neg_s2 ? $signed(-q) : $signed(q)) + c_s2;
	end

endmodule

>>> hdl/pelc_poly.sv
// ----------------------------------------------------------------------------
// pelc_poly: pipelined 2D fifth-order polynomial in (x, y)
// Five Horner steps in y run across the columns in parallel, then five
// Horner steps in x; each step is one three-stage multiply-add.
// ----------------------------------------------------------------------------
module pelc_poly #(
	parameter int STAGE = 0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              valid_in,
	input  logic        [pelc_pkg::B_W-1:0]   x,
	input  logic        [pelc_pkg::B_W-1:0]   y,
	output logic                              valid_out,
	output logic signed [pelc_pkg::ACC_W-1:0] p
);

	localparam int L  = pelc_pkg::MUL_LAT;
	localparam int NS = pelc_pkg::NSTEP;
	localparam int AW = pelc_pkg::ACC_W;

	pelc_pkg::step_t st   [NS+1];
	logic            st_v [NS+1];

	always_comb begin
		st[0].x = x;
		st[0].y = y;
		for (int m = 0; m < 6; m++) begin
			st[0].a[m] = pelc_pkg::coef_q(STAGE, m, 5 - m);
		end
	end
	assign st_v[0] = valid_in;

	for (genvar k = 0; k < NS; k++) begin : g_step
		pelc_pkg::step_t       dat_q [L];
		logic [L-1:0]          vld_q;
		logic [5:0][AW-1:0]    res;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q <= '0;
			end else begin
				vld_q <= {vld_q[L-2:0], st_v[k]};
			end
		end

		always_ff @(posedge clk) begin
			dat_q[0] <= st[k];
			for (int i = 1; i < L; i++) begin
				dat_q[i] <= dat_q[i-1];
			end
		end

		for (genvar m = 0; m < 6; m++) begin : g_col
			if (k < 5 && m <= k) begin : g_ystep
				localparam logic signed [AW-1:0] C = pelc_pkg::coef_q(STAGE, m, 4 - k);
				logic signed [AW-1:0] mres;
				pelc_muladd u_mul (
					.clk (clk),
					.a   ($signed(st[k].a[m])),
					.b   (st[k].y),
					.c   (C),
					.p   (mres)
				);
				assign res[m] = mres;
			end else if (k >= 5 && m == 5) begin : g_xstep
				logic signed [AW-1:0] mres;
				pelc_muladd u_mul (
					.clk (clk),
					.a   ($signed(st[k].a[5])),
					.b   (st[k].x),
					.c   ($signed(st[k].a[9-k])),
					.p   (mres)
				);
				assign res[m] = mres;
			end else begin : g_hold
				assign res[m] = dat_q[L-1].a[m];
			end
		end

		always_comb begin
			st[k+1].x = dat_q[L-1].x;
			st[k+1].y = dat_q[L-1].y;
			st[k+1].a = res;
		end
		assign st_v[k+1] = vld_q[L-1];
	end

	assign valid_out = st_v[NS];
	assign p         = $signed(st[NS].a[5]);

endmodule

>>> hdl/proton_energy_loss_chain_unit.sv
// ----------------------------------------------------------------------------
// proton_energy_loss_chain_unit: scintillator, air and half-carbon energy loss
// Accepts one item per clock (busy stays low) and returns its three stage
// energies, with done high for one cycle. The path runs through three
// chained polynomial pipelines of ten multiply-add steps each, every step a
// three-stage 58 x 41 bit multiplier, plus four register stages for
// clamping, rounding and output. The result cannot be held off: sample it
// in the cycle that done is high.
// ----------------------------------------------------------------------------
module proton_energy_loss_chain_unit #(
	parameter int ENERGY_FRAC_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  pelc_pkg::cmd_t       cmd,
	output logic                 done,
	output pelc_pkg::result_t    result
);

	localparam int F   = ENERGY_FRAC_BITS;
	localparam int P   = pelc_pkg::POLY_LAT;
	localparam int BW  = pelc_pkg::B_W;
	localparam int AW  = pelc_pkg::ACC_W;
	localparam int TOTAL_LAT = 3 * P + 4;
	localparam logic [BW-1:0] E_LO = BW'(pelc_pkg::E_LO_MEV) << F;
	localparam logic [BW-1:0] E_HI = BW'(pelc_pkg::E_HI_MEV) << F;

	function automatic logic [BW-1:0] energy_x(logic [16:0] raw);
		logic [BW-1:0] v;
		v = BW'(raw);
		if (v < E_LO) v = E_LO;
		if (v > E_HI) v = E_HI;
		return v << (pelc_pkg::QBITS - 8 - F);
	endfunction

	function automatic logic [BW-1:0] clamp_y(logic [41:0] v, logic [41:0] lo, logic [41:0] hi);
		logic [41:0] r;
		r = (v < lo) ? lo : ((v > hi) ? hi : v);
		return r[BW-1:0];
	endfunction

	function automatic logic [16:0] to_raw(logic signed [AW-1:0] pv);
		logic [AW-1:0] s;
		logic [AW-1:0] v;
		s = $unsigned(pv) + (AW'(1) << (pelc_pkg::QBITS - 1 - F));
		v = s >> (pelc_pkg::QBITS - F);
		if (pv <= 0) return '0;
		if (v > AW'(pelc_pkg::OUT_MAX)) return pelc_pkg::OUT_MAX;
		return v[16:0];
	endfunction

	logic                 accept;
	logic                 valid_s1;
	logic [BW-1:0]        x0_s1;
	logic [BW-1:0]        ys_s1;
	logic [BW-1:0]        ya_s1;
	logic [BW-1:0]        yc_s1;
	logic                 p1_v;
	logic signed [AW-1:0] p1;
	logic                 valid_s2;
	logic [16:0]          e1_s2;
	logic                 p2_v;
	logic signed [AW-1:0] p2;
	logic                 valid_s3;
	logic [16:0]          e2_s3;
	logic                 p3_v;
	logic signed [AW-1:0] p3;
	logic [BW-1:0]        ya_q [P+1];
	logic [BW-1:0]        yc_q [2*P+2];
	logic [16:0]          e1_q [2*P+1];
	logic [16:0]          e2_q [P];

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= p1_v;
			valid_s3 <= p2_v;
			done     <= p3_v;
		end
	end

	always_ff @(posedge clk) begin
		x0_s1 <= energy_x(cmd.energy_in);
		ys_s1 <= clamp_y(42'(cmd.scint_path) << 28, pelc_pkg::YS_LO, pelc_pkg::YS_HI);
		ya_s1 <= clamp_y(42'(cmd.air_path) << 26, pelc_pkg::YA_LO, pelc_pkg::YA_HI);
		yc_s1 <= clamp_y(42'(cmd.carbon_path) << 26, pelc_pkg::YC_LO, pelc_pkg::YC_HI);
		e1_s2 <= to_raw(p1);
		e2_s3 <= to_raw(p2);
		ya_q[0] <= ya_s1;
		for (int i = 1; i < P + 1; i++) ya_q[i] <= ya_q[i-1];
		yc_q[0] <= yc_s1;
		for (int i = 1; i < 2 * P + 2; i++) yc_q[i] <= yc_q[i-1];
		e1_q[0] <= e1_s2;
		for (int i = 1; i < 2 * P + 1; i++) e1_q[i] <= e1_q[i-1];
		e2_q[0] <= e2_s3;
		for (int i = 1; i < P; i++) e2_q[i] <= e2_q[i-1];
		result.energy_after_scint <= e1_q[2*P];
		result.energy_after_air   <= e2_q[P-1];
		result.energy_mid_carbon  <= to_raw(p3);
	end

	pelc_poly #(.STAGE(0)) u_scint (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (valid_s1),
		.x         (x0_s1),
		.y         (ys_s1),
		.valid_out (p1_v),
		.p         (p1)
	);

	pelc_poly #(.STAGE(1)) u_air (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (valid_s2),
		.x         (energy_x(e1_s2)),
		.y         (ya_q[P]),
		.valid_out (p2_v),
		.p         (p2)
	);

	pelc_poly #(.STAGE(2)) u_carbon (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (valid_s3),
		.x         (energy_x(e2_s3)),
		.y         (yc_q[2*P+1]),
		.valid_out (p3_v),
		.p         (p3)
	);

	a_item_out: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##TOTAL_LAT done)
		else $error("accepted item produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, TOTAL_LAT))
		else $error("result without an accepted item");

	a_chain_valid: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $past(valid_s1, P + 1))
		else $error("air stage valid out of step with input");

endmodule

>>> bench/tb_proton_energy_loss_chain_unit.sv
// ----------------------------------------------------------------------------
// tb_proton_energy_loss_chain_unit: self-checking bench for the energy chain
// Drives directed and random items through the command interface over
// several sender idle phases. It predicts the three stage energies with an
// independent Q40 model of the chained fits and compares each result in order.
// ----------------------------------------------------------------------------
module tb_proton_energy_loss_chain_unit;

	localparam longint SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint SMIN = 64'sh8000_0000_0000_0000;
	localparam int WATCHDOG = 3000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	pelc_pkg::cmd_t cmd;
	logic done;
	pelc_pkg::result_t result;

	pelc_pkg::cmd_t pending_items[$];
	pelc_pkg::result_t stage_energies[$];
	longint fit_coef [3][6][6];
	int idle_pct;
	int errors;
	int quiet_cycles;
	bit took_item;

	proton_energy_loss_chain_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .result(result)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic longint scaled_coef(int m, int e, int shift);
		logic [63:0] mag, d, r, q;
		logic carry, b;
		int k;
		mag = (m < 0) ? 64'(-m) : 64'(m);
		d = 64'd1;
		r = '0;
		q = '0;
		for (k = 0; k < e && k < 19; k++) d = d * 64'd10;
		for (k = 0; k < 20 + shift; k++) begin
			b = (k < 20) ? mag[19-k] : 1'b0;
			carry = r[63];
			r = {r[62:0], b};
			q = {q[62:0], 1'b0};
			if (carry || r >= d) begin
				r = r - d;
				q[0] = 1'b1;
			end
		end
		if (q[63]) q = 64'h7FFF_FFFF_FFFF_FFFF;
		return (m < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint q_mul(longint a, logic [63:0] b);
		logic [63:0] mag;
		logic [127:0] p;
		logic [127:0] r;
		mag = (a < 0) ? 64'(-a) : 64'(a);
		p = {64'b0, mag} * {64'b0, b};
		r = p >> pelc_pkg::QBITS;
		if (r > 128'h7FFF_FFFF_FFFF_FFFF) r = 128'h7FFF_FFFF_FFFF_FFFF;
		return (a < 0) ? -longint'(r[63:0]) : longint'(r[63:0]);
	endfunction

	function automatic longint q_add(longint a, longint b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'(SMAX)) return SMAX;
		if (s < 65'(SMIN)) return SMIN;
		return longint'(s);
	endfunction

	function automatic longint fit_eval(int st, logic [63:0] x, logic [63:0] y);
		longint acc, a;
		int i, j;
		acc = 0;
		for (i = 5; i >= 0; i--) begin
			a = fit_coef[st][i][5-i];
			for (j = 4 - i; j >= 0; j--) a = q_add(q_mul(a, y), fit_coef[st][i][j]);
			acc = (i == 5) ? a : q_add(q_mul(acc, x), a);
		end
		return acc;
	endfunction

	function automatic logic [63:0] clamp64(logic [63:0] v, logic [63:0] lo, logic [63:0] hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic logic [63:0] norm_energy(logic [16:0] raw);
		return clamp64(64'(raw), 64'(pelc_pkg::E_LO_MEV) << 8,
			64'(pelc_pkg::E_HI_MEV) << 8) << 24;
	endfunction

	function automatic logic [16:0] round_energy(longint p);
		logic [63:0] v;
		if (p <= 0) return 17'd0;
		v = (64'(p) + (64'd1 << 31)) >> 32;
		return (v > 64'(pelc_pkg::OUT_MAX)) ? pelc_pkg::OUT_MAX : v[16:0];
	endfunction

	function automatic pelc_pkg::result_t chain_energies(pelc_pkg::cmd_t c);
		pelc_pkg::result_t r;
		logic [63:0] ys, ya, yc;
		ys = clamp64(64'(c.scint_path) << 28, 64'(pelc_pkg::YS_LO), 64'(pelc_pkg::YS_HI));
		ya = clamp64(64'(c.air_path) << 26, 64'(pelc_pkg::YA_LO), 64'(pelc_pkg::YA_HI));
		yc = clamp64(64'(c.carbon_path) << 26, 64'(pelc_pkg::YC_LO), 64'(pelc_pkg::YC_HI));
		r.energy_after_scint = round_energy(fit_eval(0, norm_energy(c.energy_in), ys));
		r.energy_after_air = round_energy(fit_eval(1, norm_energy(r.energy_after_scint), ya));
		r.energy_mid_carbon = round_energy(fit_eval(2, norm_energy(r.energy_after_air), yc));
		return r;
	endfunction

	always @(negedge clk) begin
		if (start && !took_item) begin
			start <= 1'b1;
		end else if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
			start <= 1'b1;
			cmd <= pending_items[0];
		end else begin
			start <= 1'b0;
		end
	end

	always @(posedge clk) begin
		pelc_pkg::result_t exp_r;
		took_item <= arst_n && start && !busy;
		if (arst_n) begin
			if ((start && !busy) || done) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (start && !busy) begin
				void'(pending_items.pop_front());
				stage_energies.push_back(chain_energies(cmd));
			end
			if (done) begin
				if (stage_energies.size() == 0) begin
					$error("result with no item outstanding: %h", result);
					errors++;
				end else begin
					exp_r = stage_energies.pop_front();
					if (result.energy_after_scint !== exp_r.energy_after_scint) begin
						$error("energy_after_scint exp %0d got %0d",
							exp_r.energy_after_scint, result.energy_after_scint);
						errors++;
					end
					if (result.energy_after_air !== exp_r.energy_after_air) begin
						$error("energy_after_air exp %0d got %0d",
							exp_r.energy_after_air, result.energy_after_air);
						errors++;
					end
					if (result.energy_mid_carbon !== exp_r.energy_mid_carbon) begin
						$error("energy_mid_carbon exp %0d got %0d",
							exp_r.energy_mid_carbon, result.energy_mid_carbon);
						errors++;
					end
				end
			end
			if (quiet_cycles >= WATCHDOG) begin
				$display("tb_proton_energy_loss_chain_unit: done, errors");
				$finish;
			end
		end
	end

	function automatic pelc_pkg::cmd_t mk(int e, int s, int a, int c);
		pelc_pkg::cmd_t t;
		t.energy_in = 17'(e);
		t.scint_path = 14'(s);
		t.air_path = 15'(a);
		t.carbon_path = 14'(c);
		return t;
	endfunction

	function automatic pelc_pkg::cmd_t random_item();
		pelc_pkg::cmd_t t;
		if ($urandom_range(99) < 75) begin
			t.energy_in = 17'($urandom_range(70400, 19200));
			t.scint_path = 14'($urandom_range(3380, 1331));
			t.air_path = 15'($urandom_range(16000, 6400));
			t.carbon_path = 14'($urandom_range(10240, 512));
		end else begin
			t.energy_in = 17'($urandom);
			t.scint_path = 14'($urandom);
			t.air_path = 15'($urandom);
			t.carbon_path = 14'($urandom);
		end
		return t;
	endfunction

	task automatic drain();
		while (pending_items.size() > 0 || stage_energies.size() > 0) @(posedge clk);
	endtask

	initial begin
		int st, i, j, ph, n;
		int phase_idle [4] = '{0, 55, 0, 27};
		for (st = 0; st < 3; st++)
			for (i = 0; i < 6; i++)
				for (j = 0; j < 6 - i; j++)
					fit_coef[st][i][j] = scaled_coef(pelc_pkg::COEF_M[st][i][j],
						pelc_pkg::COEF_E[st][i][j],
						pelc_pkg::QBITS + 8 * i + pelc_pkg::YBITS[st] * j);
		errors = 0;
		quiet_cycles = 0;
		idle_pct = 0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		pending_items.push_back(mk(0, 0, 0, 0));
		pending_items.push_back(mk(131071, 16383, 32767, 16383));
		pending_items.push_back(mk(19199, 1331, 6399, 511));
		pending_items.push_back(mk(19200, 1332, 6400, 512));
		pending_items.push_back(mk(70400, 3379, 16000, 10240));
		pending_items.push_back(mk(70401, 3380, 16001, 10241));
		pending_items.push_back(mk(25600, 2000, 10000, 4000));
		pending_items.push_back(mk(51200, 3000, 12000, 8000));
		pending_items.push_back(mk(70400, 1331, 6400, 512));
		pending_items.push_back(mk(19200, 3380, 16000, 10240));
		pending_items.push_back(mk(131071, 0, 0, 16383));
		pending_items.push_back(mk(0, 16383, 32767, 0));
		pending_items.push_back(mk(21845, 10922, 21845, 10922));
		pending_items.push_back(mk(43690, 5461, 10922, 5461));
		drain();

		for (ph = 0; ph < 4; ph++) begin
			idle_pct = phase_idle[ph];
			for (n = 0; n < 300; n++) pending_items.push_back(random_item());
			drain();
		end

		repeat (200) @(posedge clk);
		if (errors == 0) begin
			$display("tb_proton_energy_loss_chain_unit: done, clean");
		end else begin
			$display("tb_proton_energy_loss_chain_unit: done, errors");
		end
		$finish;
	end

endmodule

>>> sim.f
hdl/pelc_pkg.sv
hdl/pelc_muladd.sv
hdl/pelc_poly.sv
hdl/proton_energy_loss_chain_unit.sv
bench/tb_proton_energy_loss_chain_unit.sv
